>>> rtl/core/hc2cal_pkg.sv
// hc2cal_pkg: widths, reciprocal constants, month table and digit helpers
// for the hour count to calendar bcd converter; no dependencies
`timescale 1ns / 1ps

package hc2cal_pkg;

  localparam int CountW = 27;
  localparam int DivInW = CountW - 3;
  localparam int DaysW  = 23;
  localparam int YearW  = 14;
  localparam int DoyW   = 9;
  localparam int HourW  = 5;

  // floor(x / 3) = (x * RecipDiv3) >> Div3Shift, exact for 24-bit x
  localparam logic [23:0] RecipDiv3  = 24'hAAAAAB;
  localparam int          Div3Shift  = 25;
  // floor(d / 365) = (d * RecipDiv365) >> Div365Shift, exact for 23-bit d
  localparam logic [23:0] RecipDiv365 = 24'd11767034;
  localparam int          Div365Shift = 32;

  localparam logic [YearW-1:0] YearWrap    = 14'd10000;
  localparam logic [DaysW-1:0] DaysPerYear = 23'd365;

  typedef logic [CountW-1:0] count_t;
  typedef logic [3:0]        digit_t;

  localparam logic [DoyW-1:0] MonthStart [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  function automatic logic [3:0] month_index(logic [DoyW-1:0] doy);
    logic [3:0] idx;
    idx = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (doy >= MonthStart[m]) begin
        idx = 4'(m);
      end
    end
    return idx;
  endfunction

  // two bcd digits of a value below 40
  function automatic logic [5:0] two_bcd(logic [4:0] v);
    logic [1:0] tens;
    logic [4:0] ones;
    if (v >= 5'd30) begin
      tens = 2'd3;
    end else if (v >= 5'd20) begin
      tens = 2'd2;
    end else if (v >= 5'd10) begin
      tens = 2'd1;
    end else begin
      tens = 2'd0;
    end
    ones = v - 5'(tens) * 5'd10;
    return {tens, ones[3:0]};
  endfunction

  // leading decimal digit of v for a power-of-ten step, v below 10 * step
  function automatic digit_t lead_digit(logic [YearW-1:0] v, logic [YearW-1:0] step);
    digit_t d;
    d = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (int'(v) >= k * int'(step)) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

endpackage

>>> rtl/core/hour_count_to_calendar_bcd_core.sv
// hour_count_to_calendar_bcd_core: out_valid follows each accepted start through the registered stages below
// throughput one transfer per cycle; busy stays low since the receiver cannot stall
// stages: /3 product, days and hour, /365 product, year and day of year,
// month and thousands, hundreds, tens and ones
// synchronous active-low reset clears only the stage valid bits; uses hc2cal_pkg
`timescale 1ns / 1ps

module hour_count_to_calendar_bcd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  hc2cal_pkg::count_t  in_hour_count,
  output logic                out_valid,
  output logic [15:0]         out_year_bcd,
  output logic [4:0]          out_month_bcd,
  output logic [5:0]          out_day_bcd,
  output logic [5:0]          out_hour_bcd
);

  import hc2cal_pkg::*;

  logic [6:0] vld_r;
  logic       in_xfer;

  // stage 1
  logic [DivInW-1:0]   s1_x_r;
  logic [2:0]          s1_lo_r;
  logic [2*DivInW-1:0] s1_prod_r;
  // stage 2
  logic [DaysW-1:0]    s2_days_r;
  logic [HourW-1:0]    s2_hour_r;
  logic [DaysW-1:0]    s2_days_nxt;
  logic [DivInW-1:0]   s2_three_q;
  logic [DivInW-1:0]   s2_rem3;
  // stage 3
  logic [DaysW+23:0]   s3_prod_r;
  logic [DaysW-1:0]    s3_days_r;
  logic [HourW-1:0]    s3_hour_r;
  // stage 4
  logic [YearW-1:0]    s4_year_r;
  logic [DoyW-1:0]     s4_doy_r;
  logic [HourW-1:0]    s4_hour_r;
  logic [YearW-1:0]    s4_year_raw;
  logic [DaysW-1:0]    s4_year_days;
  logic [DaysW-1:0]    s4_doy_full;
  // stage 5
  logic [4:0]          s5_month_r;
  logic [5:0]          s5_day_r;
  logic [5:0]          s5_hour_r;
  digit_t              s5_th_r;
  logic [YearW-1:0]    s5_rem_r;
  logic [3:0]          s5_midx;
  logic [DoyW-1:0]     s5_dom;
  logic [5:0]          s5_month_full;
  digit_t              s5_th_nxt;
  // stage 6
  logic [4:0]          s6_month_r;
  logic [5:0]          s6_day_r;
  logic [5:0]          s6_hour_r;
  digit_t              s6_th_r;
  digit_t              s6_hu_r;
  logic [YearW-1:0]    s6_rem_r;
  digit_t              s6_hu_nxt;
  // stage 7
  digit_t              s7_te_nxt;
  logic [YearW-1:0]    s7_one_full;

  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_xfer};
    end
  end

  // divide by 24: shift by 3, then reciprocal multiply for the /3
  always_ff @(posedge clk) begin
    s1_x_r    <= in_hour_count[CountW-1:3];
    s1_lo_r   <= in_hour_count[2:0];
    s1_prod_r <= in_hour_count[CountW-1:3] * RecipDiv3;
  end

  always_comb begin
    s2_days_nxt = s1_prod_r[Div3Shift +: DaysW];
    s2_three_q  = DivInW'(s2_days_nxt) * DivInW'(3);
    s2_rem3     = s1_x_r - s2_three_q;
  end

  always_ff @(posedge clk) begin
    s2_days_r <= s2_days_nxt;
    s2_hour_r <= {s2_rem3[1:0], s1_lo_r};
  end

  always_ff @(posedge clk) begin
    s3_prod_r <= s2_days_r * RecipDiv365;
    s3_days_r <= s2_days_r;
    s3_hour_r <= s2_hour_r;
  end

  always_comb begin
    s4_year_raw  = s3_prod_r[Div365Shift +: YearW];
    s4_year_days = DaysW'(s4_year_raw) * DaysPerYear;
    s4_doy_full  = s3_days_r - s4_year_days;
  end

  always_ff @(posedge clk) begin
    s4_year_r <= (s4_year_raw >= YearWrap) ? s4_year_raw - YearWrap : s4_year_raw;
    s4_doy_r  <= s4_doy_full[DoyW-1:0];
    s4_hour_r <= s3_hour_r;
  end

  // month search against the cumulative table, thousands digit
  always_comb begin
    s5_midx       = month_index(s4_doy_r);
    s5_dom        = s4_doy_r - MonthStart[s5_midx] + DoyW'(1);
    s5_month_full = two_bcd(5'(s5_midx) + 5'd1);
    s5_th_nxt     = lead_digit(s4_year_r, 14'd1000);
  end

  always_ff @(posedge clk) begin
    s5_month_r <= s5_month_full[4:0];
    s5_day_r   <= two_bcd(s5_dom[4:0]);
    s5_hour_r  <= two_bcd(s4_hour_r);
    s5_th_r    <= s5_th_nxt;
    s5_rem_r   <= s4_year_r - YearW'(s5_th_nxt) * YearW'(1000);
  end

  always_comb begin
    s6_hu_nxt = lead_digit(s5_rem_r, 14'd100);
  end

  always_ff @(posedge clk) begin
    s6_month_r <= s5_month_r;
    s6_day_r   <= s5_day_r;
    s6_hour_r  <= s5_hour_r;
    s6_th_r    <= s5_th_r;
    s6_hu_r    <= s6_hu_nxt;
    s6_rem_r   <= s5_rem_r - YearW'(s6_hu_nxt) * YearW'(100);
  end

  always_comb begin
    s7_te_nxt   = lead_digit(s6_rem_r, 14'd10);
    s7_one_full = s6_rem_r - YearW'(s7_te_nxt) * YearW'(10);
  end

  always_ff @(posedge clk) begin
    out_year_bcd  <= {s6_th_r, s6_hu_r, s7_te_nxt, s7_one_full[3:0]};
    out_month_bcd <= s6_month_r;
    out_day_bcd   <= s6_day_r;
    out_hour_bcd  <= s6_hour_r;
  end

  assign out_valid = vld_r[6];

endmodule

>>> verif/testbench.sv
// testbench: drives hour counts into hour_count_to_calendar_bcd_core and checks each
// bcd date against a predictor of its own; depends on hc2cal_pkg and the core rtl
`timescale 1ns / 1ps

module testbench;

  import hc2cal_pkg::*;

  localparam int unsigned MaxInRange  = 87599999;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 2000;
  localparam int unsigned DrainCycles = 20;

  localparam int unsigned MonthFirstDay [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };

  typedef struct packed {
    logic [15:0] year;
    logic [4:0]  month;
    logic [5:0]  day;
    logic [5:0]  hour;
  } date_bcd_t;

  class calendar_scoreboard;
    date_bcd_t pending_dates[$];
    int        mismatches;

    function new();
      mismatches = 0;
    endfunction

    function logic [7:0] bcd2(int unsigned v);
      return {4'((v / 10) % 10), 4'(v % 10)};
    endfunction

    function date_bcd_t hours_to_date(count_t count);
      int unsigned hour, days, year, doy, month;
      logic [7:0]  month_b, day_b, hour_b;
      date_bcd_t   d;
      hour  = count % 24;
      days  = count / 24;
      year  = (days / 365) % 10000;
      doy   = days % 365;
      month = 0;
      for (int m = 1; m < 12; m++) begin
        if (doy >= MonthFirstDay[m]) begin
          month = m;
        end
      end
      month_b = bcd2(month + 1);
      day_b   = bcd2(doy - MonthFirstDay[month] + 1);
      hour_b  = bcd2(hour);
      d.year  = {4'((year / 1000) % 10), 4'((year / 100) % 10),
                 4'((year / 10) % 10), 4'(year % 10)};
      d.month = month_b[4:0];
      d.day   = day_b[5:0];
      d.hour  = hour_b[5:0];
      return d;
    endfunction

    function void note_hour_count(count_t count);
      pending_dates.push_back(hours_to_date(count));
    endfunction

    function void check_date(date_bcd_t got);
      date_bcd_t want;
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_dates.pop_front();
      if (want.year != got.year) begin
        $display("%0t: year_bcd expected %h actual %h", $time, want.year, got.year);
        mismatches++;
      end
      if (want.month != got.month) begin
        $display("%0t: month_bcd expected %h actual %h", $time, want.month, got.month);
        mismatches++;
      end
      if (want.day != got.day) begin
        $display("%0t: day_bcd expected %h actual %h", $time, want.day, got.day);
        mismatches++;
      end
      if (want.hour != got.hour) begin
        $display("%0t: hour_bcd expected %h actual %h", $time, want.hour, got.hour);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        start         = 1'b0;
  count_t      in_hour_count = '0;
  logic        busy;
  logic        out_valid;
  logic [15:0] out_year_bcd;
  logic [4:0]  out_month_bcd;
  logic [5:0]  out_day_bcd;
  logic [5:0]  out_hour_bcd;

  calendar_scoreboard sb = new();
  int unsigned idle_pct = 0;
  int unsigned cycle_count = 0;

  hour_count_to_calendar_bcd_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_hour_count (in_hour_count),
    .out_valid     (out_valid),
    .out_year_bcd  (out_year_bcd),
    .out_month_bcd (out_month_bcd),
    .out_day_bcd   (out_day_bcd),
    .out_hour_bcd  (out_hour_bcd)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        sb.note_hour_count(in_hour_count);
      end
      if (out_valid) begin
        sb.check_date({out_year_bcd, out_month_bcd, out_day_bcd, out_hour_bcd});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL hour_count_to_calendar_bcd_core");
      $finish;
    end
  end

  task automatic send_count(input count_t value);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_hour_count <= value;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  // mostly in-range counts, many near month and year edges, some full-width
  function automatic count_t random_count();
    int unsigned pick;
    int          days;
    pick = $urandom_range(99);
    if (pick < 55) begin
      return count_t'($urandom_range(MaxInRange));
    end else if (pick < 80) begin
      days = $urandom_range(9999) * 365 + MonthFirstDay[$urandom_range(11)]
             - 1 + $urandom_range(2);
      if (days < 0) begin
        days = 0;
      end
      return count_t'(days * 24 + $urandom_range(23));
    end else if (pick < 92) begin
      return count_t'($urandom());
    end else begin
      return count_t'(MaxInRange - 50 + $urandom_range(100));
    end
  endfunction

  initial begin
    int unsigned directed [$];
    directed = '{
      0, 9, 10, 19, 20, 23, 24, 30 * 24 + 23, 31 * 24, 58 * 24 + 23, 59 * 24,
      333 * 24 + 23, 334 * 24, 364 * 24 + 23, 365 * 24,
      1000 * 8760 - 1, 1000 * 8760, MaxInRange, MaxInRange + 1, 32'h07FFFFFF,
      32'h05555555, 32'h02AAAAAA
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      send_count(count_t'(directed[i]));
    end
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 64;
        2: idle_pct = 0;
        default: idle_pct = 10;
      endcase
      for (int n = 0; n < RandomItems / 4; n++) begin
        send_count(random_count());
      end
    end
    start <= 1'b0;
    while (sb.pending_dates.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS hour_count_to_calendar_bcd_core");
    end else begin
      $display("FAIL hour_count_to_calendar_bcd_core");
    end
    $finish;
  end

endmodule
